// ===== sv/itst_pkg.sv =====
// ----------------------------------------------------------------------------
// itst_pkg
// Shared types, constants and the byte-wise CRC-16 step for the image tag
// and CRC stamper.
// ----------------------------------------------------------------------------
package itst_pkg;

    // Default width of the image length register and position counter.
    localparam int LENGTH_BITS_DEF = 24;

    // Configuration port geometry.
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ID    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_VERSION_WORD = 2'd2;

    // Trailer size and CRC seed.
    localparam int          TRAILER_BYTES = 8;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;

    // Trailer field offsets, counted from the first trailer byte.
    localparam logic [2:0] TRL_VERSION_LO = 3'd4;
    localparam logic [2:0] TRL_VERSION_HI = 3'd5;

    // One result item.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } itst_result_t;

    // One byte of the reflected CRC-16-CCITT (polynomial 0x8408).
    function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                             input logic [7:0]  b);
        logic [7:0]  d;
        logic [15:0] r;
        d = b ^ crc[7:0];
        d = d ^ {d[3:0], 4'b0000};
        r = {d, crc[15:8]};
        r = r ^ {12'h000, d[7:4]} ^ {5'b00000, d, 3'b000};
        return r;
    endfunction

endpackage

// ===== sv/itst_trailer.sv =====
// ----------------------------------------------------------------------------
// itst_trailer
// Position counter and running CRC. Substitutes the trailer fields and the
// CRC into the byte stream and flags the final byte of each image.
// ----------------------------------------------------------------------------
module itst_trailer #(
    parameter int LENGTH_BITS = itst_pkg::LENGTH_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic [7:0]                data_in,
    input  logic [LENGTH_BITS-1:0]    image_length,
    input  logic [31:0]               device_id,
    input  logic [15:0]               version_word,
    output itst_pkg::itst_result_t    result
);
    import itst_pkg::*;

    localparam logic [LENGTH_BITS-1:0] TRL_LEN = LENGTH_BITS'(TRAILER_BYTES);
    localparam logic [LENGTH_BITS-1:0] ONE     = LENGTH_BITS'(1);
    localparam logic [LENGTH_BITS-1:0] TWO     = LENGTH_BITS'(2);

    logic [LENGTH_BITS-1:0] pos_reg, pos_next;
    logic [15:0]            crc_reg, crc_next;
    logic [LENGTH_BITS-1:0] len_eff;
    logic [LENGTH_BITS-1:0] trl_start;
    logic [LENGTH_BITS-1:0] trl_off;
    logic                   is_last;
    logic                   is_crc_lo;
    logic                   in_trailer;
    logic [7:0]             byte_sel;

    // Saturate short lengths to the trailer size.
    assign len_eff   = (image_length < TRL_LEN) ? TRL_LEN : image_length;
    assign trl_start = len_eff - TRL_LEN;
    assign trl_off   = pos_reg - trl_start;

    assign is_last    = (pos_reg >= len_eff - ONE);
    assign is_crc_lo  = (pos_reg == len_eff - TWO);
    assign in_trailer = (pos_reg >= trl_start);

    // Pick the output byte: CRC, trailer field or pass-through data.
    always_comb
    begin
        byte_sel = data_in;
        if (is_last)
        begin
            byte_sel = crc_reg[15:8];
        end
        else if (is_crc_lo)
        begin
            byte_sel = crc_reg[7:0];
        end
        else if (in_trailer)
        begin
            case (trl_off[2:0])
                3'd0:           byte_sel = device_id[7:0];
                3'd1:           byte_sel = device_id[15:8];
                3'd2:           byte_sel = device_id[23:16];
                3'd3:           byte_sel = device_id[31:24];
                TRL_VERSION_LO: byte_sel = version_word[7:0];
                TRL_VERSION_HI: byte_sel = version_word[15:8];
                default:        byte_sel = data_in;
            endcase
        end
    end

    // Next position and CRC; both restart after the final byte.
    always_comb
    begin
        if (is_last)
        begin
            pos_next = '0;
            crc_next = CRC_INIT;
        end
        else
        begin
            pos_next = pos_reg + ONE;
            crc_next = (is_crc_lo) ? crc_reg : crc_byte(crc_reg, byte_sel);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            crc_reg <= CRC_INIT;
        end
        else if (advance)
        begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
        end
    end

    assign result.data = byte_sel;
    assign result.last = is_last;

    // The image restarts after every final byte.
    a_restart_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_last) |=> (pos_reg == '0))
        else $error("position did not restart after the final byte");

    a_restart_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_last) |=> (crc_reg == CRC_INIT))
        else $error("CRC did not reseed after the final byte");

    // The CRC holds while its low byte is being emitted.
    a_crc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_crc_lo && !is_last) |=> $stable(crc_reg))
        else $error("CRC changed while emitting its low byte");

endmodule

// ===== sv/itst_outbuf.sv =====
// ----------------------------------------------------------------------------
// itst_outbuf
// Two-entry output buffer: a result register and a skid register, so the
// upstream side sees a registered stall.
// ----------------------------------------------------------------------------
module itst_outbuf (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  itst_pkg::itst_result_t push_data,
    output logic                   full,
    output logic                   out_valid,
    input  logic                   out_stall,
    output itst_pkg::itst_result_t out_data
);
    import itst_pkg::*;

    logic         main_valid_reg;
    logic         skid_valid_reg;
    itst_result_t main_reg;
    itst_result_t skid_reg;
    logic         pop;

    assign pop       = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            main_reg <= skid_reg;
        end
        else if (push && (pop || !main_valid_reg))
        begin
            main_reg <= push_data;
        end
        if (push && main_valid_reg && !pop)
        begin
            skid_reg <= push_data;
        end
    end

    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held without a result entry");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && skid_valid_reg))
        else $error("push into a full output buffer");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && skid_valid_reg) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid entry not moved into the result register");

endmodule

// ===== sv/image_tag_crc_stamper_unit.sv =====
// ----------------------------------------------------------------------------
// image_tag_crc_stamper_unit
// An input transfer reaches out_valid through the input register, then the
// result register. Throughput: one byte per cycle while out_stall is low;
// the CRC step and position compares sit between those two registers.
// Reset clears the pipeline, sets image_length to 8, the trailer fields to
// zero, the position to zero and the CRC to 0xFFFF.
// ----------------------------------------------------------------------------
module image_tag_crc_stamper_unit #(
    parameter int LENGTH_BITS = itst_pkg::LENGTH_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [itst_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [itst_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        in_byte,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        out_byte,
    output logic                              last_byte
);
    import itst_pkg::*;

    logic [LENGTH_BITS-1:0] image_length_reg;
    logic [31:0]            device_id_reg;
    logic [15:0]            version_word_reg;

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   advance;
    logic                   buf_full;
    logic                   in_take;
    itst_result_t           step_result;
    itst_result_t           out_result;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_length_reg <= LENGTH_BITS'(TRAILER_BYTES);
            device_id_reg    <= '0;
            version_word_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_IMAGE_LENGTH: image_length_reg <= cfg_data[LENGTH_BITS-1:0];
                CFG_DEVICE_ID:    device_id_reg    <= cfg_data[31:0];
                CFG_VERSION_WORD: version_word_reg <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    // Input register: drains into the output buffer whenever it has room.
    assign advance  = in_valid_reg && !buf_full;
    assign in_stall = in_valid_reg && buf_full;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= in_byte;
        end
    end

    // Trailer substitution and CRC.
    itst_trailer #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_trailer (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .data_in      (in_byte_reg),
        .image_length (image_length_reg),
        .device_id    (device_id_reg),
        .version_word (version_word_reg),
        .result       (step_result)
    );

    // Result register with skid entry.
    itst_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .push_data (step_result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_result)
    );

    assign out_byte  = out_result.data;
    assign last_byte = out_result.last;

    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid))
        else $error("input stalled with no pending result");

    a_input_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !buf_full) |=> out_valid)
        else $error("input byte did not reach the output buffer");

    a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && buf_full) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("held input byte was lost");

endmodule
